/* hw/rtl/nles_pkg.sv */
`default_nettype none

package nles_pkg;

  localparam int unsigned CoordW    = 16;
  localparam int unsigned GridW     = 16;
  localparam int unsigned DistW     = 34;
  localparam int unsigned DimsW     = 3;
  localparam int unsigned FieldDims = 4;
  localparam int unsigned EntryOutW = 10;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_DRAIN = 2'd2,
    ST_FETCH = 2'd3
  } state_e;

  // one scan beat travelling down the cell row
  typedef struct packed {
    logic valid;
    logic last;
  } beat_t;

endpackage

`default_nettype wire

/* hw/rtl/nearest_library_entry_search.sv */
// nearest library entry search
// command channel: a request is taken at a clock edge where start is high and busy
// is low. cmd_i selects clear, load or query; coordinates are signed q8.8, grid
// words are stored alongside a loaded entry. dims_in_use_i is written through
// dims_we_i; the user must do so while the block is idle, as the block does not enforce it.
// result channel: done_o is high for exactly one cycle with status and payload;
// the receiver cannot hold it off, so every result is taken as it appears.
// clear, load and unused commands never raise busy: their result appears in the
// cycle after the request, and a new request may be taken in every cycle.
// a query over N stored entries streams one entry a cycle down a row of one cell
// per compared dimension (min(MAX_DIMS,4) cells, three register stages each),
// then a running minimum and a grid word read. busy stays high through the
// scan, drain and fetch states, and done_o follows in the next cycle.
// a query on an empty table answers in the next cycle without scanning.
// reset empties the table and sets dims_in_use to 4; stored entries are not
// cleared and need no clearing pass.
`default_nettype none

module nearest_library_entry_search #(
  parameter int unsigned ENTRIES  = 1024,
  parameter int unsigned MAX_DIMS = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               dims_we_i,
  input  wire logic [2:0]         dims_in_use_i,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         cmd_i,
  input  wire logic signed [15:0] coord_a_i,
  input  wire logic signed [15:0] coord_b_i,
  input  wire logic signed [15:0] coord_c_i,
  input  wire logic signed [15:0] coord_d_i,
  input  wire logic [15:0]        grid_a_i,
  input  wire logic [15:0]        grid_b_i,
  input  wire logic [15:0]        grid_c_i,
  input  wire logic [15:0]        grid_d_i,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic [9:0]              best_entry_o,
  output logic [33:0]             best_distance_o,
  output logic [15:0]             near_a_o,
  output logic [15:0]             near_b_o,
  output logic [15:0]             near_c_o,
  output logic [15:0]             near_d_o
);

  localparam int unsigned Lim = (MAX_DIMS < nles_pkg::FieldDims) ? MAX_DIMS
                                                                  : nles_pkg::FieldDims;
  localparam int unsigned AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW  = $clog2(ENTRIES + 1);
  localparam int unsigned IW  = (AW > nles_pkg::EntryOutW) ? AW : nles_pkg::EntryOutW;
  localparam int unsigned GW  = nles_pkg::GridW;
  localparam int unsigned DW  = nles_pkg::DistW;

  nles_pkg::state_e state_q, state_d;
  nles_pkg::cmd_e   cmd;

  logic [CW-1:0]                  count_q, count_d;
  logic [AW-1:0]                  scan_q, scan_d;
  logic [nles_pkg::DimsW-1:0]     dims_q;
  logic [nles_pkg::DimsW-1:0]     nd;

  logic                           accept;
  logic                           full;
  logic                           empty;
  logic                           load_we;
  logic                           query_go;
  logic                           last_hit;
  logic                           min_done;
  nles_pkg::beat_t                issue;

  logic signed [nles_pkg::CoordW-1:0] coord_in [nles_pkg::FieldDims];
  logic [GW-1:0]                  grid_in [nles_pkg::FieldDims];
  logic [Lim*GW-1:0]              grid_wr;
  logic [Lim*GW-1:0]              grid_mem_q [ENTRIES];
  logic [Lim*GW-1:0]              grid_rd_q;

  nles_pkg::beat_t                beat [Lim+1];
  logic [AW-1:0]                  idx_s [Lim+1];
  logic [DW-1:0]                  sum_s [Lim+1];

  logic [AW-1:0]                  best_idx;
  logic [DW-1:0]                  best_sum;
  logic [IW-1:0]                  best_ext;

  logic                           done_q, done_d;
  nles_pkg::status_e              status_q, status_d;
  logic [nles_pkg::EntryOutW-1:0] entry_q, entry_d;
  logic [DW-1:0]                  dist_q, dist_d;
  logic [GW-1:0]                  near_q [nles_pkg::FieldDims];
  logic [GW-1:0]                  near_d [nles_pkg::FieldDims];

  assign cmd         = nles_pkg::cmd_e'(cmd_i);
  assign coord_in[0] = coord_a_i;
  assign coord_in[1] = coord_b_i;
  assign coord_in[2] = coord_c_i;
  assign coord_in[3] = coord_d_i;
  assign grid_in[0]  = grid_a_i;
  assign grid_in[1]  = grid_b_i;
  assign grid_in[2]  = grid_c_i;
  assign grid_in[3]  = grid_d_i;

  assign accept   = start && !busy;
  assign full     = (count_q == CW'(ENTRIES));
  assign empty    = (count_q == '0);
  assign load_we  = accept && (cmd == nles_pkg::CMD_LOAD) && !full;
  assign query_go = accept && (cmd == nles_pkg::CMD_QUERY) && !empty;
  assign last_hit = ((CW'(scan_q) + CW'(1)) == count_q);

  // dimension count clamped to the carried coordinates
  always_comb begin
    if (dims_q == '0) begin
      nd = nles_pkg::DimsW'(1);
    end else if (dims_q > nles_pkg::DimsW'(Lim)) begin
      nd = nles_pkg::DimsW'(Lim);
    end else begin
      nd = dims_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nles_pkg::ST_IDLE: begin
        if (query_go) begin
          state_d = nles_pkg::ST_SCAN;
        end
      end
      nles_pkg::ST_SCAN: begin
        if (last_hit) begin
          state_d = nles_pkg::ST_DRAIN;
        end
      end
      nles_pkg::ST_DRAIN: begin
        if (min_done) begin
          state_d = nles_pkg::ST_FETCH;
        end
      end
      nles_pkg::ST_FETCH: begin
        state_d = nles_pkg::ST_IDLE;
      end
      default: begin
        state_d = nles_pkg::ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    busy        = (state_q != nles_pkg::ST_IDLE);
    issue.valid = (state_q == nles_pkg::ST_SCAN);
    issue.last  = (state_q == nles_pkg::ST_SCAN) && last_hit;
    scan_d      = (state_q == nles_pkg::ST_SCAN) ? scan_q + AW'(1) : '0;
  end

  always_comb begin
    count_d = count_q;
    if (accept && (cmd == nles_pkg::CMD_CLEAR)) begin
      count_d = '0;
    end else if (load_we) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nles_pkg::ST_IDLE;
      count_q <= '0;
      scan_q  <= '0;
      dims_q  <= nles_pkg::DimsW'(4);
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      done_q  <= done_d;
      if (dims_we_i) begin
        dims_q <= dims_in_use_i;
      end
    end
  end

  // grid words of the table, read at the running best position
  generate
    for (genvar j = 0; j < Lim; j++) begin : g_gwr
      assign grid_wr[j*GW +: GW] = grid_in[j];
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      grid_mem_q[count_q[AW-1:0]] <= grid_wr;
    end
    grid_rd_q <= grid_mem_q[best_idx];
  end

  // row of dimension cells
  assign beat[0]  = issue;
  assign idx_s[0] = scan_q;
  assign sum_s[0] = '0;

  generate
    for (genvar k = 0; k < Lim; k++) begin : g_cell
      localparam logic [nles_pkg::DimsW-1:0] K = nles_pkg::DimsW'(k);
      nles_cell #(
        .DEPTH (ENTRIES),
        .AW    (AW)
      ) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .wr_en_i   (load_we),
        .wr_addr_i (count_q[AW-1:0]),
        .wr_data_i (coord_in[k]),
        .q_we_i    (query_go),
        .q_data_i  (coord_in[k]),
        .en_i      (K < nd),
        .beat_i    (beat[k]),
        .idx_i     (idx_s[k]),
        .sum_i     (sum_s[k]),
        .beat_o    (beat[k+1]),
        .idx_o     (idx_s[k+1]),
        .sum_o     (sum_s[k+1])
      );
    end
  endgenerate

  nles_min #(
    .AW (AW)
  ) u_min (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (query_go),
    .beat_i     (beat[Lim]),
    .idx_i      (idx_s[Lim]),
    .sum_i      (sum_s[Lim]),
    .best_idx_o (best_idx),
    .best_sum_o (best_sum),
    .done_o     (min_done)
  );

  assign best_ext = IW'(best_idx);

  // result request
  always_comb begin
    done_d   = (accept && !query_go) || (state_q == nles_pkg::ST_FETCH);
    status_d = nles_pkg::STATUS_OK;
    entry_d  = '0;
    dist_d   = '0;
    if (accept && (cmd == nles_pkg::CMD_LOAD) && full) begin
      status_d = nles_pkg::STATUS_FULL;
    end else if (accept && (cmd == nles_pkg::CMD_QUERY) && empty) begin
      status_d = nles_pkg::STATUS_EMPTY;
    end
    if (state_q == nles_pkg::ST_FETCH) begin
      entry_d = best_ext[nles_pkg::EntryOutW-1:0];
      dist_d  = best_sum;
    end
  end

  generate
    for (genvar j = 0; j < nles_pkg::FieldDims; j++) begin : g_near
      localparam logic [nles_pkg::DimsW-1:0] J = nles_pkg::DimsW'(j);
      if (j < Lim) begin : g_used
        assign near_d[j] = ((state_q == nles_pkg::ST_FETCH) && (J < nd))
                           ? grid_rd_q[j*GW +: GW] : '0;
      end else begin : g_unused
        assign near_d[j] = '0;
      end
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    entry_q  <= entry_d;
    dist_q   <= dist_d;
    for (int j = 0; j < nles_pkg::FieldDims; j++) begin
      near_q[j] <= near_d[j];
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign best_entry_o    = entry_q;
  assign best_distance_o = dist_q;
  assign near_a_o        = near_q[0];
  assign near_b_o        = near_q[1];
  assign near_c_o        = near_q[2];
  assign near_d_o        = near_q[3];

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ENTRIES))
    else $error("entry count beyond table depth");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nles_pkg::ST_SCAN) |-> (count_q != '0))
    else $error("scan running over an empty table");

  a_min_done_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    min_done |-> (state_q == nles_pkg::ST_DRAIN))
    else $error("scan finished outside drain");

  a_fetch_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nles_pkg::ST_FETCH) |=> (done_q && (status_q == nles_pkg::STATUS_OK)))
    else $error("query result missing after fetch");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q == nles_pkg::STATUS_EMPTY)) |-> ((dist_q == '0) && (entry_q == '0)))
    else $error("empty query carries a payload");

endmodule

`default_nettype wire

/* hw/rtl/nles_cell.sv */
`default_nettype none

module nles_cell #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 wr_en_i,
  input  wire logic [AW-1:0]                        wr_addr_i,
  input  wire logic signed [nles_pkg::CoordW-1:0]   wr_data_i,
  input  wire logic                                 q_we_i,
  input  wire logic signed [nles_pkg::CoordW-1:0]   q_data_i,
  input  wire logic                                 en_i,
  input  wire nles_pkg::beat_t                      beat_i,
  input  wire logic [AW-1:0]                        idx_i,
  input  wire logic [nles_pkg::DistW-1:0]           sum_i,
  output nles_pkg::beat_t                           beat_o,
  output logic [AW-1:0]                             idx_o,
  output logic [nles_pkg::DistW-1:0]                sum_o
);

  logic signed [nles_pkg::CoordW-1:0] mem_q [DEPTH];
  logic signed [nles_pkg::CoordW-1:0] rd_q;
  logic signed [nles_pkg::CoordW-1:0] qry_q;

  nles_pkg::beat_t b1_q, b2_q, b3_q;
  logic [AW-1:0] idx1_q, idx2_q, idx3_q;
  logic [nles_pkg::DistW-1:0] sum1_q, sum2_q, sum3_q;
  logic [nles_pkg::DistW-1:0] prod_q, prod_d;

  logic signed [nles_pkg::CoordW:0] diff;
  logic [nles_pkg::CoordW:0]        mag;
  logic [2*nles_pkg::CoordW-1:0]    sq;

  // column of the coordinate table for this dimension
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem_q[idx_i];
  end

  always_ff @(posedge clk_i) begin
    if (q_we_i) begin
      qry_q <= q_data_i;
    end
  end

  // difference magnitude never exceeds 16 bits
  always_comb begin
    diff   = {qry_q[nles_pkg::CoordW-1], qry_q} - {rd_q[nles_pkg::CoordW-1], rd_q};
    mag    = diff[nles_pkg::CoordW] ? -diff : diff;
    sq     = mag[nles_pkg::CoordW-1:0] * mag[nles_pkg::CoordW-1:0];
    prod_d = en_i ? nles_pkg::DistW'(sq) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_q <= '0;
      b2_q <= '0;
      b3_q <= '0;
    end else begin
      b1_q <= beat_i;
      b2_q <= b1_q;
      b3_q <= b2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= idx_i;
    sum1_q <= sum_i;
    idx2_q <= idx1_q;
    sum2_q <= sum1_q;
    prod_q <= prod_d;
    idx3_q <= idx2_q;
    sum3_q <= sum2_q + prod_q;
  end

  assign beat_o = b3_q;
  assign idx_o  = idx3_q;
  assign sum_o  = sum3_q;

endmodule

`default_nettype wire

/* hw/rtl/nles_min.sv */
`default_nettype none

module nles_min #(
  parameter int unsigned AW = 10
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         clear_i,
  input  wire nles_pkg::beat_t              beat_i,
  input  wire logic [AW-1:0]                idx_i,
  input  wire logic [nles_pkg::DistW-1:0]   sum_i,
  output logic [AW-1:0]                     best_idx_o,
  output logic [nles_pkg::DistW-1:0]        best_sum_o,
  output logic                              done_o
);

  logic                         have_q;
  logic                         done_q;
  logic [AW-1:0]                best_idx_q;
  logic [nles_pkg::DistW-1:0]   best_sum_q;
  logic                         take;

  // strict compare keeps the earliest entry on a tie
  assign take = beat_i.valid && (!have_q || (sum_i < best_sum_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (clear_i) begin
        have_q <= 1'b0;
      end else if (beat_i.valid) begin
        have_q <= 1'b1;
      end
      done_q <= beat_i.valid && beat_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_idx_q <= idx_i;
      best_sum_q <= sum_i;
    end
  end

  assign best_idx_o = best_idx_q;
  assign best_sum_o = best_sum_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire
